// ----- hw/rtl/scm_pkg.sv -----
// Shared constants, types and the state encoding of the sample covariance matrix core.
// No dependencies; every other file but scm_ram imports this package.
package scm_pkg;

   localparam int MAX_SAMPLES  = 256;
   localparam int MAX_FEATURES = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int STORE_DEPTH  = MAX_SAMPLES * MAX_FEATURES;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int ROWS_W       = 9;
   localparam int COLS_W       = 4;
   localparam int IDX_W        = 3;
   localparam int COV_W        = 33;
   localparam int SUM_W        = 25;
   localparam int PROD_W       = 2 * SAMPLE_WIDTH;
   localparam int SXY_W        = 40;
   localparam int NUM_W        = 49;
   localparam int MAG_W        = NUM_W - 1;
   localparam int DIV_W        = 16;
   localparam int STEP_W       = $clog2(MAG_W);
   localparam int TOTAL_W      = ADDR_W + 1;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = ROWS_W;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SAMPLES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_FEATURES = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_NUMER,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic issue;
      logic mul;
      logic numer;
      logic div_step;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic load_last;
      logic rows_done;
      logic pipe_busy;
      logic div_done;
      logic last_entry;
   } status_type;

endpackage

// ----- hw/rtl/scm_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module scm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ----- hw/rtl/scm_ctrl.sv -----
// Controller state machine of the sample covariance matrix core.
// Depends on scm_pkg; drives scm_datapath through cmd_type.
module scm_ctrl
   import scm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       emit
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && status.load_last) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (status.rows_done && !status.pipe_busy) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_NUMER;
         ST_NUMER: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            state_in = status.last_entry ? ST_IDLE : ST_SUM;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            cmd.load  = start;
            cmd.clear = start && status.load_last;
         end
         ST_SUM:   cmd.issue    = !status.rows_done;
         ST_MUL:   cmd.mul      = 1'b1;
         ST_NUMER: cmd.numer    = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_EMIT: begin
            emit        = 1'b1;
            cmd.advance = 1'b1;
            cmd.clear   = !status.last_entry;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// ----- hw/rtl/scm_datapath.sv -----
// Datapath: sample store, multiply-accumulate pass, numerator and bit-serial divider.
// Depends on scm_pkg and scm_ram; commanded by scm_ctrl.
module scm_datapath
   import scm_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic                           csr_write_enable,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_write_data,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
   output logic [IDX_W-1:0]               row_index,
   output logic [IDX_W-1:0]               col_index,
   output logic signed [COV_W-1:0]        covariance,
   output logic                           last_flag
);

   logic [ROWS_W-1:0] rows_ff;
   logic [COLS_W-1:0] cols_ff;
   logic [ROWS_W-1:0] eff_n;
   logic [COLS_W-1:0] eff_m;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0] count_next;

   logic [ADDR_W-1:0] load_count_ff;
   logic [IDX_W-1:0]  i_ff, j_ff;
   logic [ROWS_W-1:0] u_ff;
   logic [ADDR_W-1:0] base_ff;
   logic              v1_ff, v2_ff;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic [SAMPLE_WIDTH-1:0] data_a, data_b;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sx_ff, sy_ff;
   logic signed [SXY_W-1:0]  sxy_ff;
   logic signed [NUM_W-1:0]  nsxy_ff, sxsy_ff;
   logic [DIV_W-1:0]         d_ff;
   logic signed [NUM_W:0]    nsxy_full;
   logic signed [2*SUM_W-1:0] sxsy_full;
   logic [2*ROWS_W-1:0]      d_full;
   logic signed [NUM_W-1:0]  num;

   logic              neg_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIV_W:0]    trial;
   logic              qbit;
   logic [COV_W-1:0]  capped;
   logic              last_ij;

   always_comb begin
      eff_n = rows_ff;
      if (rows_ff < ROWS_W'(2)) eff_n = ROWS_W'(2);
      else if (rows_ff > ROWS_W'(MAX_SAMPLES)) eff_n = ROWS_W'(MAX_SAMPLES);
      eff_m = cols_ff;
      if (cols_ff == '0) eff_m = COLS_W'(1);
      else if (cols_ff > COLS_W'(MAX_FEATURES)) eff_m = COLS_W'(MAX_FEATURES);
   end

   assign total      = TOTAL_W'(eff_n) * TOTAL_W'(eff_m);
   assign count_next = {1'b0, load_count_ff} + TOTAL_W'(1);
   assign last_ij    = (i_ff == IDX_W'(eff_m - COLS_W'(1)))
                    && (j_ff == IDX_W'(eff_m - COLS_W'(1)));

   assign addr_a = base_ff + ADDR_W'(i_ff);
   assign addr_b = base_ff + ADDR_W'(j_ff);

   scm_ram #(
      .WIDTH(SAMPLE_WIDTH),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (cmd.load),
      .wr_addr   (load_count_ff),
      .wr_data   (sample_value),
      .rd_addr_a (addr_a),
      .rd_data_a (data_a),
      .rd_addr_b (addr_b),
      .rd_data_b (data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff       <= ROWS_W'(2);
         cols_ff       <= COLS_W'(1);
         load_count_ff <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NUM_SAMPLES:  rows_ff <= csr_write_data;
               CSR_NUM_FEATURES: cols_ff <= csr_write_data[COLS_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            if (count_next >= total) begin
               load_count_ff <= '0;
               i_ff          <= '0;
               j_ff          <= '0;
            end else begin
               load_count_ff <= count_next[ADDR_W-1:0];
            end
         end
         if (cmd.advance) begin
            if (j_ff == IDX_W'(eff_m - COLS_W'(1))) begin
               j_ff <= '0;
               i_ff <= i_ff + IDX_W'(1);
            end else begin
               j_ff <= j_ff + IDX_W'(1);
            end
         end
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   assign nsxy_full = (NUM_W+1)'(sxy_ff) * (NUM_W+1)'($signed({1'b0, eff_n}));
   assign sxsy_full = (2*SUM_W)'(sx_ff) * (2*SUM_W)'(sy_ff);
   assign d_full    = (2*ROWS_W)'(eff_n) * (2*ROWS_W)'(eff_n - ROWS_W'(1));
   assign num       = nsxy_ff - sxsy_ff;

   assign trial = {rem_ff, mag_ff[MAG_W-1]};
   assign qbit  = (trial >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         u_ff    <= '0;
         base_ff <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         sxy_ff  <= '0;
      end else begin
         if (cmd.issue) begin
            u_ff    <= u_ff + ROWS_W'(1);
            base_ff <= base_ff + ADDR_W'(eff_m);
         end
         if (v1_ff) begin
            sx_ff   <= sx_ff + SUM_W'($signed(data_a));
            sy_ff   <= sy_ff + SUM_W'($signed(data_b));
         end
         if (v2_ff) begin
            sxy_ff  <= sxy_ff + SXY_W'(prod_ff);
         end
      end
      if (v1_ff) begin
         prod_ff <= PROD_W'($signed(data_a)) * PROD_W'($signed(data_b));
      end
      if (cmd.mul) begin
         nsxy_ff <= NUM_W'(nsxy_full);
         sxsy_ff <= NUM_W'(sxsy_full);
         d_ff    <= DIV_W'(d_full);
      end
      if (cmd.numer) begin
         neg_ff  <= num[NUM_W-1];
         mag_ff  <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
         rem_ff  <= '0;
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= qbit ? DIV_W'(trial - {1'b0, d_ff}) : trial[DIV_W-1:0];
         mag_ff  <= {mag_ff[MAG_W-2:0], qbit};
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      if (neg_ff) begin
         capped = (mag_ff > MAG_W'(64'h1_0000_0000)) ? COV_W'(64'h1_0000_0000)
                                                     : mag_ff[COV_W-1:0];
         covariance = $signed(-capped);
      end else begin
         capped = (mag_ff > MAG_W'(64'hFFFF_FFFF)) ? COV_W'(64'hFFFF_FFFF)
                                                   : mag_ff[COV_W-1:0];
         covariance = $signed(capped);
      end
   end

   assign row_index = i_ff;
   assign col_index = j_ff;
   assign last_flag = last_ij;

   assign status.load_last  = (count_next >= total);
   assign status.rows_done  = (u_ff == eff_n);
   assign status.pipe_busy  = v1_ff || v2_ff;
   assign status.div_done   = (step_ff == STEP_W'(MAG_W - 1));
   assign status.last_entry = last_ij;

endmodule

// ----- hw/rtl/sample_covariance_matrix_core.sv -----
// Sample covariance matrix core: loads an n x m Q7.8 matrix row-major, then emits the
// m x m covariance matrix in Q16.16, truncated toward zero. Depends on scm_pkg, scm_ctrl,
// scm_datapath and scm_ram.
//
// Loading takes one sample per cycle while start is high and busy is low. The sample that
// completes the matrix raises busy; each of the m*m entries then passes through the single
// multiply-accumulate pass over the store's two read ports, the numerator, the bit-serial
// divider and the result ports. Each entry is shown for one cycle with rsp_valid high and
// cannot be held off; busy drops after the entry marked by rsp_last_entry.
module sample_covariance_matrix_core
   import scm_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_value,
   output logic                           rsp_valid,
   output logic [IDX_W-1:0]               rsp_row_index,
   output logic [IDX_W-1:0]               rsp_col_index,
   output logic signed [COV_W-1:0]        rsp_covariance,
   output logic                           rsp_last_entry,
   input  logic                           csr_write_enable,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_write_data
);

   cmd_type    cmd;
   status_type status;
   logic       emit;
   logic       last_flag;

   scm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .emit   (emit)
   );

   scm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sample_value     (req_sample_value),
      .row_index        (rsp_row_index),
      .col_index        (rsp_col_index),
      .covariance       (rsp_covariance),
      .last_flag        (last_flag)
   );

   assign rsp_valid      = emit;
   assign rsp_last_entry = emit && last_flag;

endmodule

// ----- hw/rtl/scm_checker.sv -----
// Port-level checks on the sample covariance matrix core, bound to the top level.
// Depends on scm_pkg and sample_covariance_matrix_core.
module scm_checker
   import scm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_entry
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("core not idle after reset");

   a_beat_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while not busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_entry |=> !busy && !rsp_valid)
      else $error("core still busy after last entry");

   a_beat_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_entry |=> !rsp_valid && busy)
      else $error("back-to-back result beats");

endmodule

bind sample_covariance_matrix_core scm_checker u_scm_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_last_entry (rsp_last_entry)
);
